@@ rtl/core/tcm_pkg.sv @@
// Shared types and constants for the tile collision map.
// No dependencies; imported by tcm_floor_div and tile_collision_map_unit.
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

   // default geometry
   localparam int MAX_COLS_DEF    = 1024;
   localparam int MAX_ROWS_DEF    = 32;
   localparam int TILE_PIXELS_DEF = 32;

   // field widths
   localparam int TILE_W     = 12;  // tile_col / tile_row
   localparam int RECT_POS_W = 16;  // rect_left / rect_top
   localparam int RECT_LEN_W = 12;  // rect_w / rect_h
   localparam int MAP_W_W    = 11;  // map_width register
   localparam int MAP_H_W    = 6;   // map_height register
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 11;

   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;

   // pixel math: first/last pixel fits 17 bits signed, tile coords 19 bits signed
   localparam int PX_W   = RECT_POS_W + 1;
   localparam int SW     = PX_W + 2;
   localparam int PX_NEG = 2 ** (RECT_POS_W - 1);  // magnitude of most negative pixel

   typedef enum logic [1:0] {
      CMD_WR_SOLID  = 2'd0,
      CMD_WR_HAZARD = 2'd1,
      CMD_RD_TILE   = 2'd2,
      CMD_RECT      = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_ACCESS,
      ST_READ,
      ST_DIV,
      ST_CLIP,
      ST_BASE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/tcm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                          wr_data,
   input  wire                                       rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tcm_floor_div.sv @@
// Floor division of a signed pixel coordinate by the tile size.
// Offset to non-negative, then exact reciprocal multiply. Uses tcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcm_floor_div #(
   parameter int TILE_PIXELS = tcm_pkg::TILE_PIXELS_DEF
) (
   input  wire  signed [tcm_pkg::PX_W-1:0] px_i,
   output logic signed [tcm_pkg::SW-1:0]   tile_o
);
   import tcm_pkg::*;

   localparam int L      = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 0;
   localparam int SH     = PX_W + L;
   localparam int OFS_T  = (PX_NEG + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam int OFS    = OFS_T * TILE_PIXELS;
   localparam longint MUL = ((longint'(1) << SH) + TILE_PIXELS - 1) / TILE_PIXELS;
   localparam int PW     = 2 * PX_W + 1;

   logic [PX_W-1:0] n;
   logic [PW-1:0]   prod;
   logic [PW-1:0]   q;

   // n stays below 2**PX_W, so MUL = ceil(2**SH / T) gives the exact quotient
   assign n      = px_i + PX_W'(OFS);
   assign prod   = PW'(n) * PW'(MUL);
   assign q      = prod >> SH;
   assign tile_o = $signed(SW'(q)) - $signed(SW'(OFS_T));

endmodule

`default_nettype wire

@@ rtl/core/tile_collision_map_unit.sv @@
// Tile collision map: solid/hazard bit grid with tile access and rectangle hazard test.
// Uses tcm_pkg, tcm_ram (two bit stores) and tcm_floor_div (four corner lanes).
//
// Usage:
//  - req_* stream carries one command per beat (tuser = command). Write commands
//    give no response; tile read and rectangle test give one rsp_* beat.
//  - csr_* writes map_width (index 0) and map_height (index 1); take effect on the
//    next command. Write only while the block is idle.
//  - Steps from accepted beat: tile write ST_ADDR, ST_ACCESS; tile read ST_ADDR,
//    ST_ACCESS, ST_READ, ST_DONE; rectangle test ST_DIV, ST_CLIP, ST_BASE, ST_SCAN
//    per tile, ST_DONE (empty or fully clipped: no scan); early exit on first hazard.
//  - Throughput is one command at a time; the rectangle scan is bound by the single
//    read port of the hazard store, one tile per cycle.
//  - Reset: both stores are swept to zero, one entry per cycle, over MAX_COLS*MAX_ROWS
//    entries (32768 at defaults); req_tready stays low during the sweep.
//  - Response stall: the response sits in an output register; the next command is
//    accepted and worked on, and only waits at its own response if the register
//    is still held by rsp_tready low.
`timescale 1ns / 1ps
`default_nettype none

module tile_collision_map_unit #(
   parameter int MAX_COLS    = tcm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS    = tcm_pkg::MAX_ROWS_DEF,
   parameter int TILE_PIXELS = tcm_pkg::TILE_PIXELS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // command beat
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // tdata: tile_col[11:0], tile_row[23:12], bit_value[24], rect_left[40:25],
   //        rect_top[56:41], rect_w[68:57], rect_h[80:69], zero pad [87:81]
   input  wire  [tcm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: command[1:0]
   input  wire  [tcm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // response beat
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // tdata: is_solid[0], is_hazard[1], overlap_hit[2], zero pad [7:3]
   output logic [tcm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // register write port
   input  wire                               csr_we,
   input  wire  [tcm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire  [tcm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcm_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int HW    = $clog2(MAX_ROWS + 1);

   // ---------------- registers ----------------
   state_type state_ff, state_in;

   logic [MAP_W_W-1:0] map_w_ff, map_w_in;
   logic [MAP_H_W-1:0] map_h_ff, map_h_in;

   // latched command
   cmd_type                       cmd_ff, cmd_in;
   logic signed [TILE_W-1:0]      tcol_ff, tcol_in;
   logic signed [TILE_W-1:0]      trow_ff, trow_in;
   logic                          bit_ff, bit_in;
   logic signed [RECT_POS_W-1:0]  x_ff, x_in;
   logic signed [RECT_POS_W-1:0]  y_ff, y_in;
   logic [RECT_LEN_W-1:0]         w_ff, w_in;
   logic [RECT_LEN_W-1:0]         h_ff, h_in;

   // tile access
   logic          inmap_ff, inmap_in;
   logic [AW-1:0] addr_ff, addr_in;

   // rectangle geometry
   logic signed [SW-1:0] ldiv_ff, ldiv_in;
   logic signed [SW-1:0] rdiv_ff, rdiv_in;
   logic signed [SW-1:0] tdiv_ff, tdiv_in;
   logic signed [SW-1:0] bdiv_ff, bdiv_in;
   logic                 empty_ff, empty_in;
   logic [CLW-1:0]       cl_left_ff, cl_left_in;
   logic [CLW-1:0]       cl_right_ff, cl_right_in;
   logic [RW-1:0]        cl_top_ff, cl_top_in;
   logic [RW-1:0]        cl_bot_ff, cl_bot_in;

   // scan cursor
   logic [CLW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0]  cur_row_ff, cur_row_in;
   logic [AW-1:0]  row_base_ff, row_base_in;
   logic           done_ff, done_in;   // last tile read issued
   logic           chk_ff, chk_in;     // read data pending check

   // result and output register
   logic                   res_solid_ff, res_solid_in;
   logic                   res_hazard_ff, res_hazard_in;
   logic                   res_hit_ff, res_hit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [AW-1:0] clr_ff, clr_in;

   // ---------------- memories ----------------
   logic          sol_we, haz_we, sol_re, haz_re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          sol_wdata, haz_wdata;
   logic [0:0]    sol_q, haz_q;

   tcm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_solid_ram (
      .clock   (clock),
      .wr_en   (sol_we),
      .wr_addr (wr_addr),
      .wr_data (sol_wdata),
      .rd_en   (sol_re),
      .rd_addr (rd_addr),
      .rd_data (sol_q)
   );

   tcm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_hazard_ram (
      .clock   (clock),
      .wr_en   (haz_we),
      .wr_addr (wr_addr),
      .wr_data (haz_wdata),
      .rd_en   (haz_re),
      .rd_addr (rd_addr),
      .rd_data (haz_q)
   );

   // ---------------- corner division lanes ----------------
   logic signed [PX_W-1:0] x_first, x_last, y_first, y_last;
   logic signed [SW-1:0]   ldiv, rdiv, tdiv, bdiv;

   assign x_first = PX_W'(x_ff);
   assign y_first = PX_W'(y_ff);
   assign x_last  = x_first + $signed(PX_W'(w_ff)) - $signed(PX_W'(1));
   assign y_last  = y_first + $signed(PX_W'(h_ff)) - $signed(PX_W'(1));

   tcm_floor_div #(.TILE_PIXELS(TILE_PIXELS)) u_div_left   (.px_i(x_first), .tile_o(ldiv));
   tcm_floor_div #(.TILE_PIXELS(TILE_PIXELS)) u_div_right  (.px_i(x_last),  .tile_o(rdiv));
   tcm_floor_div #(.TILE_PIXELS(TILE_PIXELS)) u_div_top    (.px_i(y_first), .tile_o(tdiv));
   tcm_floor_div #(.TILE_PIXELS(TILE_PIXELS)) u_div_bottom (.px_i(y_last),  .tile_o(bdiv));

   // ---------------- effective geometry ----------------
   logic [CW-1:0]        eff_w;
   logic [HW-1:0]        eff_h;
   logic signed [SW-1:0] wmax, hmax;
   logic signed [SW-1:0] lclip, rclip, tclip, bclip;
   logic                 tile_in_map;
   logic [AW-1:0]        tile_addr;
   logic [AW-1:0]        scan_addr;

   always_comb begin
      // saturate to the store geometry
      if (int'(map_w_ff) > MAX_COLS) begin
         eff_w = CW'(MAX_COLS);
      end else begin
         eff_w = CW'(map_w_ff);
      end
      if (int'(map_h_ff) > MAX_ROWS) begin
         eff_h = HW'(MAX_ROWS);
      end else begin
         eff_h = HW'(map_h_ff);
      end
   end

   assign wmax = $signed(SW'(eff_w)) - $signed(SW'(1));
   assign hmax = $signed(SW'(eff_h)) - $signed(SW'(1));

   assign lclip = (ldiv_ff < 0) ? '0 : ldiv_ff;
   assign tclip = (tdiv_ff < 0) ? '0 : tdiv_ff;
   assign rclip = (rdiv_ff > wmax) ? wmax : rdiv_ff;
   assign bclip = (bdiv_ff > hmax) ? hmax : bdiv_ff;

   assign tile_in_map = (tcol_ff >= 0) && (trow_ff >= 0) &&
                        (int'(tcol_ff) < int'(eff_w)) && (int'(trow_ff) < int'(eff_h));
   // row-major address, only meaningful when the tile is in the map
   assign tile_addr = AW'(trow_ff[RW-1:0]) * AW'(eff_w) + AW'($unsigned(tcol_ff));
   assign scan_addr = row_base_ff + AW'(cur_col_ff);

   // ---------------- next state and outputs ----------------
   always_comb begin
      state_in      = state_ff;
      map_w_in      = map_w_ff;
      map_h_in      = map_h_ff;
      cmd_in        = cmd_ff;
      tcol_in       = tcol_ff;
      trow_in       = trow_ff;
      bit_in        = bit_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      inmap_in      = inmap_ff;
      addr_in       = addr_ff;
      ldiv_in       = ldiv_ff;
      rdiv_in       = rdiv_ff;
      tdiv_in       = tdiv_ff;
      bdiv_in       = bdiv_ff;
      empty_in      = empty_ff;
      cl_left_in    = cl_left_ff;
      cl_right_in   = cl_right_ff;
      cl_top_in     = cl_top_ff;
      cl_bot_in     = cl_bot_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      row_base_in   = row_base_ff;
      done_in       = done_ff;
      chk_in        = chk_ff;
      res_solid_in  = res_solid_ff;
      res_hazard_in = res_hazard_ff;
      res_hit_in    = res_hit_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      clr_in        = clr_ff;

      req_tready = 1'b0;
      sol_we     = 1'b0;
      haz_we     = 1'b0;
      sol_re     = 1'b0;
      haz_re     = 1'b0;
      wr_addr    = addr_ff;
      rd_addr    = addr_ff;
      sol_wdata  = bit_ff;
      haz_wdata  = bit_ff;

      if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_MAP_WIDTH:  map_w_in = csr_wdata[MAP_W_W-1:0];
            REG_MAP_HEIGHT: map_h_in = csr_wdata[MAP_H_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            sol_we    = 1'b1;
            haz_we    = 1'b1;
            wr_addr   = clr_ff;
            sol_wdata = 1'b0;
            haz_wdata = 1'b0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd_in  = cmd_type'(req_tuser[1:0]);
               tcol_in = req_tdata[11:0];
               trow_in = req_tdata[23:12];
               bit_in  = req_tdata[24];
               x_in    = req_tdata[40:25];
               y_in    = req_tdata[56:41];
               w_in    = req_tdata[68:57];
               h_in    = req_tdata[80:69];
               if (cmd_type'(req_tuser[1:0]) == CMD_RECT) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end

         ST_ADDR: begin
            inmap_in = tile_in_map;
            addr_in  = tile_addr;
            state_in = ST_ACCESS;
         end

         ST_ACCESS: begin
            unique case (cmd_ff)
               CMD_WR_SOLID: begin
                  sol_we   = inmap_ff;
                  state_in = ST_IDLE;
               end
               CMD_WR_HAZARD: begin
                  haz_we   = inmap_ff;
                  state_in = ST_IDLE;
               end
               CMD_RD_TILE: begin
                  sol_re   = 1'b1;
                  haz_re   = 1'b1;
                  state_in = ST_READ;
               end
               CMD_RECT: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_READ: begin
            res_solid_in  = inmap_ff & sol_q[0];
            res_hazard_in = inmap_ff & haz_q[0];
            res_hit_in    = 1'b0;
            state_in      = ST_DONE;
         end

         ST_DIV: begin
            ldiv_in  = ldiv;
            rdiv_in  = rdiv;
            tdiv_in  = tdiv;
            bdiv_in  = bdiv;
            empty_in = (w_ff == '0) || (h_ff == '0);
            state_in = ST_CLIP;
         end

         ST_CLIP: begin
            res_solid_in  = 1'b0;
            res_hazard_in = 1'b0;
            res_hit_in    = 1'b0;
            cl_left_in    = CLW'(lclip);
            cl_right_in   = CLW'(rclip);
            cl_top_in     = RW'(tclip);
            cl_bot_in     = RW'(bclip);
            // empty box, or range clipped away entirely (covers a zero-size map)
            if (empty_ff || (lclip > rclip) || (tclip > bclip)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_BASE;
            end
         end

         ST_BASE: begin
            row_base_in = AW'(cl_top_ff) * AW'(eff_w);
            cur_col_in  = cl_left_ff;
            cur_row_in  = cl_top_ff;
            done_in     = 1'b0;
            chk_in      = 1'b0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            // one hazard read issued per cycle, checked the cycle after
            rd_addr = scan_addr;
            chk_in  = !done_ff;
            if (!done_ff) begin
               haz_re = 1'b1;
               if (cur_col_ff == cl_right_ff) begin
                  cur_col_in = cl_left_ff;
                  if (cur_row_ff == cl_bot_ff) begin
                     done_in = 1'b1;
                  end else begin
                     cur_row_in  = cur_row_ff + RW'(1);
                     row_base_in = row_base_ff + AW'(eff_w);
                  end
               end else begin
                  cur_col_in = cur_col_ff + CLW'(1);
               end
            end
            if (chk_ff && haz_q[0]) begin
               res_hit_in = 1'b1;
               state_in   = ST_DONE;
            end else if (done_ff) begin
               res_hit_in = 1'b0;
               state_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, res_hit_ff, res_hazard_ff, res_solid_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- state register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         map_w_ff     <= '0;
         map_h_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         map_w_ff     <= map_w_in;
         map_h_ff     <= map_h_in;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      tcol_ff       <= tcol_in;
      trow_ff       <= trow_in;
      bit_ff        <= bit_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      inmap_ff      <= inmap_in;
      addr_ff       <= addr_in;
      ldiv_ff       <= ldiv_in;
      rdiv_ff       <= rdiv_in;
      tdiv_ff       <= tdiv_in;
      bdiv_ff       <= bdiv_in;
      empty_ff      <= empty_in;
      cl_left_ff    <= cl_left_in;
      cl_right_ff   <= cl_right_in;
      cl_top_ff     <= cl_top_in;
      cl_bot_ff     <= cl_bot_in;
      cur_col_ff    <= cur_col_in;
      cur_row_ff    <= cur_row_in;
      row_base_ff   <= row_base_in;
      done_ff       <= done_in;
      chk_ff        <= chk_in;
      res_solid_ff  <= res_solid_in;
      res_hazard_ff <= res_hazard_in;
      res_hit_ff    <= res_hit_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> (state_ff == ST_CLEAR))
      else $error("store sweep did not start after reset");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the result stage");

   a_scan_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !done_ff) |->
         (cur_col_ff <= cl_right_ff && cur_row_ff <= cl_bot_ff &&
          int'(scan_addr) < DEPTH))
      else $error("scan cursor left the clipped tile range");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_READ) |-> !(sol_we || haz_we))
      else $error("store written during a read sequence");

endmodule

`default_nettype wire
